// ----- hdl/hbbm_pkg.sv -----
// Shared types and constants for the half bridge break-before-make driver.
// No dependencies; imported by hbbm_core and the top level.

package hbbm_pkg;

  // Field widths
  localparam int unsigned HalfPeriodW = 24;
  localparam int unsigned DeadTimeW   = 16;
  localparam int unsigned StateW      = 2;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned CfgDataW    = 24;

  // Saturation limits of the tick counters
  localparam logic [HalfPeriodW-1:0] PeriodMax = {HalfPeriodW{1'b1}};
  localparam logic [DeadTimeW-1:0]   DeadMax   = {DeadTimeW{1'b1}};

  // Dead time after reset
  localparam logic [DeadTimeW-1:0] DeadTimeReset = DeadTimeW'(1000);

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    REG_MODE        = 2'd0,
    REG_HALF_PERIOD = 2'd1,
    REG_DEAD_TIME   = 2'd2
  } cfg_reg_t;

  // Output state codes (code 3 drives as ground)
  localparam logic [StateW-1:0] ST_GROUND = 2'd0;
  localparam logic [StateW-1:0] ST_HIGH   = 2'd1;
  localparam logic [StateW-1:0] ST_HIGHZ  = 2'd2;

  // One result item
  typedef struct packed {
    logic              high_switch;
    logic              low_switch;
    logic              busy;
    logic [StateW-1:0] current_state;
  } hbbm_res_t;

endpackage

// ----- hdl/hbbm_core.sv -----
// Switching state of the half bridge driver: configuration registers, timers
// and switch levels, advanced by one tick per step strobe. Uses hbbm_pkg.

module hbbm_core
  import hbbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 step,
  input  logic                 request_valid,
  input  logic [StateW-1:0]    requested_state,
  input  logic                 pause,
  output hbbm_res_t            res_next
);

  typedef enum logic [1:0] {
    PH_STANDBY   = 2'd0,
    PH_RECONNECT = 2'd2
  } phase_t;

  // Configuration
  logic                   mode;
  logic [HalfPeriodW-1:0] half_period_ticks;
  logic [DeadTimeW-1:0]   dead_time_ticks;

  // Tick state
  phase_t                 phase,          phase_next;
  logic                   high_target,    high_target_next;
  logic                   low_target,     low_target_next;
  logic                   high_level,     high_level_next;
  logic                   low_level,      low_level_next;
  logic [DeadTimeW-1:0]   dead_counter,   dead_counter_next;
  logic [HalfPeriodW-1:0] period_counter, period_counter_next;
  logic                   toggle_bit,     toggle_bit_next;
  logic [StateW-1:0]      last_state,     last_state_next;
  logic                   pending,        pending_next;

  logic              freq;
  logic              change;
  logic [StateW-1:0] target_state;
  logic              tgt_high, tgt_low;

  assign freq = mode && (half_period_ticks != '0);

  // One tick of the switching sequence
  always_comb begin
    phase_next          = phase;
    high_target_next    = high_target;
    low_target_next     = low_target;
    high_level_next     = high_level;
    low_level_next      = low_level;
    dead_counter_next   = dead_counter;
    period_counter_next = period_counter;
    toggle_bit_next     = toggle_bit;
    last_state_next     = last_state;
    pending_next        = pending;
    change              = 1'b0;
    target_state        = ST_GROUND;

    // latch any request
    if (request_valid) begin
      last_state_next = requested_state;
      pending_next    = 1'b1;
    end

    if (period_counter != PeriodMax) begin
      period_counter_next = period_counter + 1'b1;
    end

    // change source: stored request in manual mode, half period in freq mode
    if (!freq) begin
      if (pending_next) begin
        pending_next = 1'b0;
        change       = 1'b1;
        target_state = last_state_next;
      end
    end else if (!pause && (period_counter_next >= half_period_ticks)) begin
      period_counter_next = '0;
      toggle_bit_next     = !toggle_bit;
      change              = 1'b1;
      target_state        = toggle_bit_next ? ST_HIGH : ST_GROUND;
    end

    // unused phase codes fall back to ground
    if (!change && (phase != PH_STANDBY) && (phase != PH_RECONNECT)) begin
      change       = 1'b1;
      target_state = ST_GROUND;
    end

    // targets for the chosen state
    unique case (target_state)
      ST_HIGH:  begin tgt_high = 1'b1; tgt_low = 1'b0; end
      ST_HIGHZ: begin tgt_high = 1'b0; tgt_low = 1'b0; end
      default:  begin tgt_high = 1'b0; tgt_low = 1'b1; end
    endcase

    if (change) begin
      // break: open what must go off now, restart the dead time
      high_target_next  = tgt_high;
      low_target_next   = tgt_low;
      if (!tgt_high) high_level_next = 1'b0;
      if (!tgt_low)  low_level_next  = 1'b0;
      dead_counter_next = '0;
      phase_next        = PH_RECONNECT;
    end else if (phase == PH_RECONNECT) begin
      // make: close the new switches once the dead time is out
      if (dead_counter != DeadMax) dead_counter_next = dead_counter + 1'b1;
      if (dead_counter_next >= dead_time_ticks) begin
        if (high_target) high_level_next = 1'b1;
        if (low_target)  low_level_next  = 1'b1;
        phase_next = PH_STANDBY;
      end
    end
  end

  assign res_next.high_switch   = high_level_next;
  assign res_next.low_switch    = low_level_next;
  assign res_next.busy          = (phase_next == PH_RECONNECT);
  assign res_next.current_state = last_state_next;

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= 1'b0;
      half_period_ticks <= '0;
      dead_time_ticks   <= DeadTimeReset;
      phase             <= PH_STANDBY;
      high_target       <= 1'b0;
      low_target        <= 1'b1;
      high_level        <= 1'b0;
      low_level         <= 1'b1;
      dead_counter      <= '0;
      period_counter    <= '0;
      toggle_bit        <= 1'b0;
      last_state        <= ST_GROUND;
      pending           <= 1'b0;
    end else begin
      if (step) begin
        phase          <= phase_next;
        high_target    <= high_target_next;
        low_target     <= low_target_next;
        high_level     <= high_level_next;
        low_level      <= low_level_next;
        dead_counter   <= dead_counter_next;
        period_counter <= period_counter_next;
        toggle_bit     <= toggle_bit_next;
        last_state     <= last_state_next;
        pending        <= pending_next;
      end
      // register writes; mode and half period restart the toggling
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MODE: begin
            mode           <= cfg_data[0];
            toggle_bit     <= 1'b0;
            period_counter <= '0;
            if (half_period_ticks == '0) begin
              last_state <= ST_GROUND;
              pending    <= 1'b1;
            end
          end
          REG_HALF_PERIOD: begin
            half_period_ticks <= cfg_data[HalfPeriodW-1:0];
            toggle_bit        <= 1'b0;
            period_counter    <= '0;
            if (cfg_data[HalfPeriodW-1:0] == '0) begin
              last_state <= ST_GROUND;
              pending    <= 1'b1;
            end
          end
          REG_DEAD_TIME: dead_time_ticks <= cfg_data[DeadTimeW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- hdl/half_bridge_break_before_make_top.sv -----
// Top level of the half bridge break-before-make driver: request handshake
// and result register around hbbm_core. Uses hbbm_pkg.
//
// Usage:
//   Each input request is one time tick with an optional state request
//   (request_valid, requested_state) and a pause flag. For every accepted
//   request one result is produced: the high and low switch drive levels,
//   busy_res while the dead time is being waited out, and current_state.
//   The result is registered and valid in the cycle after the request is accepted.
//   Throughput: one request per cycle; the tick update is a single pass of
//   logic from the state registers into the result register.
//   The output register lets a new request in while the previous result is
//   taken in the same cycle; when the receiver stalls with a result held,
//   in_ready drops until that result is taken.
//   Configuration: cfg_write with cfg_index (0 mode, 1 half period,
//   2 dead time) and cfg_data, written while no request is in flight.
//   Reset (rst, synchronous): manual mode, dead time 1000 ticks, low switch
//   closed, high switch open, no result pending.

module half_bridge_break_before_make_top
  import hbbm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  // tick requests
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 request_valid,
  input  logic [StateW-1:0]    requested_state,
  input  logic                 pause,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 high_switch,
  output logic                 low_switch,
  output logic                 busy_res,
  output logic [StateW-1:0]    current_state
);

  logic      accept;
  hbbm_res_t res_next;
  hbbm_res_t res;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  hbbm_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .step            (accept),
    .request_valid   (request_valid),
    .requested_state (requested_state),
    .pause           (pause),
    .res_next        (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign high_switch   = res.high_switch;
  assign low_switch    = res.low_switch;
  assign busy_res      = res.busy;
  assign current_state = res.current_state;

  // No shoot-through: both switches never closed together
  a_no_shoot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(high_switch && low_switch))
    else $error("high and low switch closed together");

  // Every accepted request yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  // A stalled result is neither dropped nor overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(res)))
    else $error("stalled result lost or changed");

endmodule
